// File: rtl/sma_pkg.sv
package sma_pkg;

   // Sizing of the array and of the element datapath.
   localparam int MAX_DIM    = 16;
   localparam int ELEM_WIDTH = 16;

   // Fixed widths of the transaction fields.
   localparam int ELEM_FIELD_W = 16;
   localparam int SUM_W        = 36;
   localparam int RC_W         = 4;
   localparam int CSR_W        = 5;

   // Derived widths.
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int NN_W    = $clog2(DEPTH + 1);
   localparam int PROD_W  = 2 * ELEM_WIDTH;

   localparam logic KIND_B = 1'b0;
   localparam logic KIND_A = 1'b1;

   typedef struct packed {
      logic                           kind;
      logic signed [ELEM_FIELD_W-1:0] element;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] product_sum;
      logic [RC_W-1:0]         row;
      logic [RC_W-1:0]         column;
      logic                    last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DRAIN,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic shift_b;
      logic mul;
      logic acc;
      logic first;
      logic shift_sum;
   } cell_ctl_type;

   // Dimension in use for a written value: zero acts as one, large values saturate.
   function automatic logic [DIM_W-1:0] dim_clamp(input logic [CSR_W-1:0] value);
      logic [DIM_W-1:0] result;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (int'(value) > MAX_DIM) begin
         result = DIM_W'(MAX_DIM);
      end else begin
         result = DIM_W'(value);
      end
      return result;
   endfunction

   function automatic logic [NN_W-1:0] dim_square(input logic [DIM_W-1:0] d);
      logic [NN_W-1:0] wide;
      wide = NN_W'(d);
      return NN_W'(wide * wide);
   endfunction

   localparam logic [DIM_W-1:0] N_RESET  = DIM_W'((16 > MAX_DIM) ? MAX_DIM : 16);
   localparam logic [NN_W-1:0]  NN_RESET = dim_square(N_RESET);

endpackage

// File: rtl/sma_ram.sv
module sma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sma_cell.sv
module sma_cell (
   input  logic                                   clock,
   input  sma_pkg::cell_ctl_type                  ctl,
   input  logic signed [sma_pkg::ELEM_WIDTH-1:0]  a_value,
   input  logic signed [sma_pkg::ELEM_WIDTH-1:0]  b_from_prev,
   output logic signed [sma_pkg::ELEM_WIDTH-1:0]  b_to_next,
   input  logic signed [sma_pkg::SUM_W-1:0]       sum_from_next,
   output logic signed [sma_pkg::SUM_W-1:0]       sum_to_prev
);
   import sma_pkg::*;

   logic signed [ELEM_WIDTH-1:0] b_ff, b_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [SUM_W-1:0]      sum_base;

   always_comb begin
      b_in    = ctl.shift_b ? b_from_prev : b_ff;
      prod_in = ctl.mul ? PROD_W'(a_value * b_ff) : prod_ff;
      // A new row of A starts its column sum from zero.
      sum_base = ctl.first ? '0 : sum_ff;
      if (ctl.shift_sum) begin
         sum_in = sum_from_next;
      end else if (ctl.acc) begin
         sum_in = sum_base + SUM_W'(prod_ff);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_ff    <= b_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign b_to_next   = b_ff;
   assign sum_to_prev = sum_ff;

endmodule

// File: rtl/square_matrix_multiply.sv
// B element: one transaction per cycle while idle, written straight into the B memory.
// A element: the single B memory read port (n = dim in use) fetches the n entries
// of one B row into the cell chain one per cycle, before the next request is taken.
// At a row end the n C elements of the row are output; the first is valid once
// the last A element of the row has passed the LOAD, DRAIN, MUL, ACC and EMIT states.
// Reset is synchronous and active high: counters clear, dim returns to 16, B stays unknown.
module square_matrix_multiply (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sma_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sma_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [sma_pkg::CSR_W-1:0]     csr_write_data
);
   import sma_pkg::*;

   // Sequencer state and the progress counters of the A and B streams.
   state_type              state_ff, state_in;
   logic [DIM_W-1:0]       n_ff, n_in;
   logic [NN_W-1:0]        nn_ff, nn_in;
   logic [ADDR_W-1:0]      b_idx_ff, b_idx_in;
   logic [IDX_W-1:0]       a_col_ff, a_col_in;
   logic [IDX_W-1:0]       a_row_ff, a_row_in;
   logic [ADDR_W-1:0]      row_base_ff, row_base_in;
   logic [IDX_W-1:0]       rd_j_ff, rd_j_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]       emit_cnt_ff, emit_cnt_in;
   logic signed [ELEM_WIDTH-1:0] a_val_ff, a_val_in;

   // Output register that parts the cell chain from the result channel.
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   b_write;
   logic                   emit_load;
   logic                   emit_last;
   logic                   col_last;
   logic                   row_last;
   logic                   b_wrap;
   logic [IDX_W-1:0]       n_m1;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ELEM_WIDTH-1:0]  rd_data;
   cell_ctl_type           cell_ctl;

   logic signed [ELEM_WIDTH-1:0] b_chain   [MAX_DIM+1];
   logic signed [SUM_W-1:0]      sum_chain [MAX_DIM+1];

   assign n_m1       = IDX_W'(n_ff - DIM_W'(1));
   assign req_accept = req_valid && req_ready;
   assign b_write    = req_accept && (req_data.kind == KIND_B);
   assign col_last   = (a_col_ff == n_m1);
   assign row_last   = (a_row_ff == n_m1);
   assign emit_last  = (emit_cnt_ff == n_m1);
   assign b_wrap     = ((NN_W'(b_idx_ff) + NN_W'(1)) == nn_ff);

   // B is stored flat in row-major order, exactly as it arrives.
   sma_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_write),
      .wr_addr (b_idx_ff),
      .wr_data (req_data.element[ELEM_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The B row is read from the last column down to column zero, so after n shifts
   // into cell zero, cell j holds b[k][j]. During output the column sums move the
   // other way, and cell zero always presents the next C element.
   assign rd_addr           = row_base_ff + ADDR_W'(rd_j_ff);
   assign b_chain[0]        = rd_data;
   assign sum_chain[MAX_DIM] = '0;

   for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
      sma_cell u_cell (
         .clock         (clock),
         .ctl           (cell_ctl),
         .a_value       (a_val_ff),
         .b_from_prev   (b_chain[c]),
         .b_to_next     (b_chain[c+1]),
         .sum_from_next (sum_chain[c+1]),
         .sum_to_prev   (sum_chain[c])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.kind == KIND_A)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (rd_j_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            state_in = col_last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (emit_load && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready          = 1'b0;
      rd_en              = 1'b0;
      emit_load          = 1'b0;
      cell_ctl           = '0;
      cell_ctl.shift_b   = rd_valid_ff;
      cell_ctl.first     = (a_col_ff == '0);
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_LOAD:  rd_en = 1'b1;
         ST_DRAIN: ;
         ST_MUL:   cell_ctl.mul = 1'b1;
         ST_ACC:   cell_ctl.acc = 1'b1;
         ST_EMIT: begin
            emit_load          = !rsp_valid_ff || rsp_ready;
            cell_ctl.shift_sum = emit_load;
         end
         default: ;
      endcase
   end

   // Counters, operand and output register.
   always_comb begin
      n_in        = n_ff;
      nn_in       = nn_ff;
      b_idx_in    = b_idx_ff;
      a_col_in    = a_col_ff;
      a_row_in    = a_row_ff;
      row_base_in = row_base_ff;
      rd_j_in     = rd_j_ff;
      emit_cnt_in = emit_cnt_ff;
      a_val_in    = a_val_ff;
      rd_valid_in = rd_en;

      if (csr_write_enable) begin
         // A new dimension restarts both streams; B contents are kept.
         n_in        = dim_clamp(csr_write_data);
         nn_in       = dim_square(n_in);
         b_idx_in    = '0;
         a_col_in    = '0;
         a_row_in    = '0;
         row_base_in = '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (b_write) begin
                  b_idx_in = b_wrap ? '0 : b_idx_ff + ADDR_W'(1);
               end else if (req_accept) begin
                  a_val_in = req_data.element[ELEM_WIDTH-1:0];
                  rd_j_in  = n_m1;
               end
            end
            ST_LOAD: rd_j_in = rd_j_ff - IDX_W'(1);
            ST_ACC: begin
               if (col_last) begin
                  a_col_in    = '0;
                  row_base_in = '0;
                  emit_cnt_in = '0;
               end else begin
                  a_col_in    = a_col_ff + IDX_W'(1);
                  row_base_in = row_base_ff + ADDR_W'(n_ff);
               end
            end
            ST_EMIT: begin
               if (emit_load) begin
                  emit_cnt_in = emit_cnt_ff + IDX_W'(1);
                  if (emit_last) begin
                     a_row_in = row_last ? '0 : a_row_ff + IDX_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end

      rsp_data_in = rsp_data_ff;
      if (emit_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.product_sum = sum_chain[0];
         rsp_data_in.row         = RC_W'(a_row_ff);
         rsp_data_in.column      = RC_W'(emit_cnt_ff);
         rsp_data_in.last        = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= N_RESET;
         nn_ff        <= NN_RESET;
         b_idx_ff     <= '0;
         a_col_ff     <= '0;
         a_row_ff     <= '0;
         row_base_ff  <= '0;
         rd_j_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         nn_ff        <= nn_in;
         b_idx_ff     <= b_idx_in;
         a_col_ff     <= a_col_in;
         a_row_ff     <= a_row_in;
         row_base_ff  <= row_base_in;
         rd_j_ff      <= rd_j_in;
         rd_valid_ff  <= rd_valid_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_val_ff    <= a_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A B entry only shifts into the chain in the cycle after it was read.
   a_shift_follows_read : assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff) == ST_LOAD)
      else $error("B shift without a preceding memory read");

   // Output of a row only starts right after its last accumulation.
   a_emit_after_acc : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && $past(state_ff) != ST_EMIT) |-> $past(state_ff) == ST_ACC)
      else $error("row output started without accumulation");

   // The column and row positions within A never reach the dimension.
   a_col_in_range : assert property (@(posedge clock) disable iff (reset)
      a_col_ff <= n_m1 && a_row_ff <= n_m1)
      else $error("A position beyond the dimension in use");

endmodule
